/* hdl/nsr_pkg.sv */
// ----------------------------------------------------------------------------
// Newton square root package
// Shared widths, codes and the status structs that pass between the divider,
// the squaring unit and the sequencer.
// ----------------------------------------------------------------------------
package nsr_pkg;

  // Field widths of the channels and registers.
  localparam int IN_W          = 32;
  localparam int ROOT_W        = 32;
  localparam int RES_ROOT_W    = 25;
  localparam int STATUS_W      = 2;
  localparam int ITER_W        = 13;
  localparam int TOL_W         = 16;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 16;
  localparam int DEF_FRAC_BITS = 16;

  // Reset value of the iteration cap.
  localparam logic [ITER_W-1:0] ITER_RESET = 13'd4096;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_CONVERGED = 2'd0,
    ST_NEGATIVE  = 2'd1,
    ST_CAP       = 2'd2
  } status_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_ITER  = 1'b0,
    REG_TOLERANCE = 1'b1
  } cfg_reg_e;

  // Divider status towards the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Squaring unit result towards the sequencer.
  typedef struct packed {
    logic valid;
    logic in_tol;
  } sq_stat_t;

endpackage

/* hdl/nsr_if.sv */
// ----------------------------------------------------------------------------
// Newton square root channel interfaces
// Operand, result and configuration write channels, each with valid/ready.
// ----------------------------------------------------------------------------
interface nsr_operand_if;
  logic                            valid;
  logic                            ready;
  logic signed [nsr_pkg::IN_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface nsr_result_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [nsr_pkg::RES_ROOT_W-1:0] root;
  logic        [nsr_pkg::STATUS_W-1:0]   status;

  modport source (output valid, output root, output status, input ready);
  modport sink   (input valid, input root, input status, output ready);
endinterface

interface nsr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [nsr_pkg::CFG_IDX_W-1:0]     index;
  logic [nsr_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/nsr_divider.sv */
// ----------------------------------------------------------------------------
// Newton square root divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nsr_divider #(
  parameter int NUM_W = 47,
  parameter int DEN_W = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [NUM_W-1:0]       numerator,
  input  logic [DEN_W-1:0]       denominator,
  output nsr_pkg::div_stat_t     stat,
  output logic [NUM_W-1:0]       quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W:0]   rem;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] den;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // Shift the next numerator bit into the partial remainder and try a subtract.
  assign trial = {rem[DEN_W-1:0], quo[NUM_W-1]};
  assign diff  = trial - {1'b0, den};
  assign fits  = (trial >= {1'b0, den});

  // Control: the count runs down once per quotient bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits enter where numerator bits leave.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= numerator;
      den <= denominator;
    end else if (busy) begin
      rem <= fits ? diff : trial;
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

/* hdl/nsr_square.sv */
// ----------------------------------------------------------------------------
// Newton square root squaring unit
// Squares the iterate and tests it against the scaled operand, three stages.
// ----------------------------------------------------------------------------
module nsr_square #(
  parameter int FRAC_BITS = nsr_pkg::DEF_FRAC_BITS,
  parameter int VS_W      = 47
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [nsr_pkg::ROOT_W-1:0]  root,
  input  logic [VS_W-1:0]             vs,
  input  logic [nsr_pkg::TOL_W-1:0]   tol,
  output nsr_pkg::sq_stat_t           stat
);

  localparam int PROD_W = 2 * nsr_pkg::ROOT_W;

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] vs_ext;
  logic [PROD_W-1:0] gap;
  logic [PROD_W-1:0] tol_sh;
  logic [VS_W-1:0]   vs_r;
  logic              v1;
  logic              v2;
  logic              v3;
  logic              in_tol;

  assign vs_ext = {{(PROD_W-VS_W){1'b0}}, vs_r};
  assign tol_sh = {{(PROD_W-nsr_pkg::TOL_W){1'b0}}, tol} << FRAC_BITS;

  // Stage valids.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Square, then absolute distance, then the tolerance compare.
  always_ff @(posedge clk) begin
    if (start) begin
      prod <= {{nsr_pkg::ROOT_W{1'b0}}, root} * {{nsr_pkg::ROOT_W{1'b0}}, root};
      vs_r <= vs;
    end
    if (v1) begin
      gap <= (prod > vs_ext) ? (prod - vs_ext) : (vs_ext - prod);
    end
    if (v2) begin
      in_tol <= (gap <= tol_sh);
    end
  end

  assign stat.valid  = v3;
  assign stat.in_tol = in_tol;

endmodule

/* hdl/newton_square_root.sv */
// ----------------------------------------------------------------------------
// Newton square root
// Fixed-point square root by Newton-Raphson iteration on a shared divider.
// ----------------------------------------------------------------------------
// Usage: the operand channel takes one signed fixed-point value per
// transaction; the result channel returns its root and a status code
// (converged, negative input, iteration cap reached). The configuration
// channel writes the iteration cap and the tolerance; it is only ready
// while the block is idle, and it takes precedence over a waiting operand.
// Sequencing: negative, zero and exactly-one operands go straight to the
// result without iterating. Any other operand runs Newton updates, each a
// square test and then a bit-serial divide at one quotient bit per cycle,
// and ends on the square test or when an update leaves the root unchanged;
// the number of updates is data dependent and at most the cap.
// One operand is worked on at a time.
// The result sits in an output register: a new operand is accepted while a
// result waits, but a finished root is held internally until the receiver
// takes the previous one, so a stalled receiver stalls the block.
// Reset clears all control state, sets the cap to 4096 and the tolerance
// to zero; no transaction is in flight after reset.
// ----------------------------------------------------------------------------
module newton_square_root #(
  parameter int FRAC_BITS = nsr_pkg::DEF_FRAC_BITS
) (
  input  logic          clk,
  input  logic          rst,
  nsr_operand_if.sink   operand,
  nsr_result_if.source  result,
  nsr_cfg_if.sink       cfg
);

  localparam int VS_W = nsr_pkg::IN_W - 1 + FRAC_BITS;
  localparam int IP_W = nsr_pkg::IN_W - 1 - FRAC_BITS;
  localparam logic [nsr_pkg::ROOT_W-1:0] ONE_FX = nsr_pkg::ROOT_W'(1) << FRAC_BITS;
  localparam logic [nsr_pkg::RES_ROOT_W-1:0] RES_NEG =
    nsr_pkg::RES_ROOT_W'(0) - (nsr_pkg::RES_ROOT_W'(1) << FRAC_BITS);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SQUARE = 5'b00010,
    S_TEST   = 5'b00100,
    S_DIVIDE = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t                           state;
  logic [nsr_pkg::ITER_W-1:0]       max_iter;
  logic [nsr_pkg::TOL_W-1:0]        tol;
  logic [nsr_pkg::ITER_W-1:0]       iter;
  logic [nsr_pkg::ROOT_W-1:0]       root;
  logic [VS_W-1:0]                  vs;
  logic [nsr_pkg::RES_ROOT_W-1:0]   res_root;
  logic [nsr_pkg::STATUS_W-1:0]     res_status;
  logic                             out_valid;
  logic [nsr_pkg::RES_ROOT_W-1:0]   out_root;
  logic [nsr_pkg::STATUS_W-1:0]     out_status;

  logic                             take_in;
  logic                             take_cfg;
  logic                             out_free;
  logic                             sq_start;
  logic                             div_start;
  nsr_pkg::sq_stat_t                sq_stat;
  nsr_pkg::div_stat_t               div_stat;
  logic [VS_W-1:0]                  div_quo;
  logic [nsr_pkg::ROOT_W-1:0]       divisor;
  logic [VS_W:0]                    upd_sum;
  logic [nsr_pkg::ROOT_W-1:0]       upd_next;

  logic [VS_W-1:0]                  in_vs;
  logic [IP_W-1:0]                  in_ipart;
  logic [IP_W-1:0]                  in_ipart_adj;
  logic [nsr_pkg::ROOT_W-1:0]       in_guess;
  logic                             in_neg;
  logic                             in_zero;
  logic                             in_one;

  // Handshakes: configuration wins over an operand in the idle state.
  assign cfg.ready     = (state == S_IDLE);
  assign operand.ready = (state == S_IDLE) && !cfg.valid;
  assign take_cfg      = cfg.valid && cfg.ready;
  assign take_in       = operand.valid && operand.ready;
  assign out_free      = !out_valid || result.ready;

  // Operand decode and starting guess.
  assign in_neg       = operand.value[nsr_pkg::IN_W-1];
  assign in_zero      = (operand.value == '0);
  assign in_one       = ($unsigned(operand.value) == ONE_FX);
  assign in_vs        = {operand.value[nsr_pkg::IN_W-2:0], {FRAC_BITS{1'b0}}};
  assign in_ipart     = operand.value[nsr_pkg::IN_W-2:FRAC_BITS];
  assign in_ipart_adj = ((operand.value[FRAC_BITS-1:0] == '0) && (in_ipart != '0))
                        ? in_ipart - 1'b1 : in_ipart;
  assign in_guess     = (in_ipart_adj == '0) ? ONE_FX
                        : {1'b0, in_ipart_adj, {FRAC_BITS{1'b0}}};

  // Newton update from the divider quotient.
  assign divisor  = (root == '0) ? ONE_FX : root;
  assign upd_sum  = {{(VS_W+1-nsr_pkg::ROOT_W){1'b0}}, root} + {1'b0, div_quo};
  assign upd_next = upd_sum[nsr_pkg::ROOT_W:1];

  // Unit launches.
  assign sq_start  = (state == S_SQUARE);
  assign div_start = (state == S_TEST) && sq_stat.valid && !sq_stat.in_tol &&
                     (iter < max_iter);

  nsr_square #(
    .FRAC_BITS (FRAC_BITS),
    .VS_W      (VS_W)
  ) u_square (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .root  (root),
    .vs    (vs),
    .tol   (tol),
    .stat  (sq_stat)
  );

  nsr_divider #(
    .NUM_W (VS_W),
    .DEN_W (nsr_pkg::ROOT_W)
  ) u_divider (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .numerator   (vs),
    .denominator (divisor),
    .stat        (div_stat),
    .quotient    (div_quo)
  );

  // Sequencer and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      max_iter  <= nsr_pkg::ITER_RESET;
      tol       <= '0;
    end else begin
      if (take_cfg) begin
        unique case (nsr_pkg::cfg_reg_e'(cfg.index))
          nsr_pkg::REG_MAX_ITER:  max_iter <= cfg.data[nsr_pkg::ITER_W-1:0];
          nsr_pkg::REG_TOLERANCE: tol      <= cfg.data[nsr_pkg::TOL_W-1:0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (take_in) begin
            iter <= '0;
            vs   <= in_vs;
            root <= in_guess;
            if (in_neg) begin
              res_root   <= RES_NEG;
              res_status <= nsr_pkg::ST_NEGATIVE;
              state      <= S_DONE;
            end else if (in_zero) begin
              res_root   <= '0;
              res_status <= nsr_pkg::ST_CONVERGED;
              state      <= S_DONE;
            end else if (in_one) begin
              res_root   <= ONE_FX[nsr_pkg::RES_ROOT_W-1:0];
              res_status <= nsr_pkg::ST_CONVERGED;
              state      <= S_DONE;
            end else begin
              state <= S_SQUARE;
            end
          end
        end
        S_SQUARE: begin
          state <= S_TEST;
        end
        S_TEST: begin
          if (sq_stat.valid) begin
            if (sq_stat.in_tol) begin
              res_root   <= root[nsr_pkg::RES_ROOT_W-1:0];
              res_status <= nsr_pkg::ST_CONVERGED;
              state      <= S_DONE;
            end else if (iter >= max_iter) begin
              res_root   <= root[nsr_pkg::RES_ROOT_W-1:0];
              res_status <= nsr_pkg::ST_CAP;
              state      <= S_DONE;
            end else begin
              state <= S_DIVIDE;
            end
          end
        end
        S_DIVIDE: begin
          if (div_stat.done) begin
            iter <= iter + 1'b1;
            if (upd_next == root) begin
              res_root   <= root[nsr_pkg::RES_ROOT_W-1:0];
              res_status <= nsr_pkg::ST_CONVERGED;
              state      <= S_DONE;
            end else begin
              root  <= upd_next;
              state <= S_SQUARE;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: loaded when the sequencer finishes, emptied when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid  <= 1'b1;
      out_root   <= res_root;
      out_status <= res_status;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result.valid  = out_valid;
  assign result.root   = out_root;
  assign result.status = out_status;

  // The divider is only launched when it is free.
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider launched while busy");

  // A quotient only arrives while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DIVIDE))
    else $error("divider finished outside the divide state");

  // The square test only completes while the sequencer waits for it.
  a_sq_done: assert property (@(posedge clk) disable iff (rst)
    sq_stat.valid |-> (state == S_TEST))
    else $error("square test finished outside the test state");

  // No update is started once the cap is used up.
  a_iter_cap: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVIDE) |-> (iter < max_iter))
    else $error("Newton update beyond the iteration cap");

  // A negative operand always reports minus one.
  a_neg_root: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.status == nsr_pkg::ST_NEGATIVE)) |->
      (result.root == RES_NEG))
    else $error("negative status with a root other than minus one");

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// Newton square root testbench
// Feeds signed fixed-point operands and register writes to the square root
// block, predicts every root and status code in step with the configuration,
// and checks the result channel against them under random idling on both
// sides.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS     = nsr_pkg::DEF_FRAC_BITS;
  localparam int CLK_PERIOD    = 8;
  localparam int RESET_CYCLES  = 4;
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 60;
  localparam int TOTAL_ITEMS   = 21 + RANDOM_PHASES * PHASE_ITEMS;
  localparam int END_CYCLES    = 500;
  localparam int UPDATE_CYCLES = nsr_pkg::IN_W + FRAC_BITS + 4;

  localparam logic [63:0] ONE_FX = 64'd1 << FRAC_BITS;

  typedef enum logic {
    CMD_OPERAND,
    CMD_REG_WRITE
  } cmd_kind_e;

  // One pending transaction for either the operand or the register channel.
  typedef struct packed {
    cmd_kind_e                       kind;
    nsr_pkg::cfg_reg_e               reg_index;
    logic [nsr_pkg::CFG_DATA_W-1:0]  data;
    logic signed [nsr_pkg::IN_W-1:0] value;
  } port_cmd_t;

  // Expected root and status, with the operand that caused them.
  typedef struct packed {
    logic signed [nsr_pkg::IN_W-1:0] value;
    logic [nsr_pkg::RES_ROOT_W-1:0]  root;
    nsr_pkg::status_e                status;
  } root_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  nsr_operand_if operand_ch ();
  nsr_result_if  result_ch ();
  nsr_cfg_if     cfg_ch ();

  port_cmd_t    pending_cmds[$];
  root_result_t expected_roots[$];

  logic [nsr_pkg::ITER_W-1:0] iter_cap_reg;
  logic [nsr_pkg::TOL_W-1:0]  tolerance_reg;
  int unsigned       planned_cap = nsr_pkg::ITER_RESET;
  int unsigned       operands_accepted = 0;
  int unsigned       work_outstanding = 0;
  int unsigned       failures = 0;
  longint unsigned   cycle_allowance = 2000;
  longint unsigned   cycle_count = 0;

  newton_square_root #(
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .operand (operand_ch),
    .result  (result_ch),
    .cfg     (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Root and status for one operand under the given cap and tolerance.
  function automatic root_result_t predict_root(logic signed [nsr_pkg::IN_W-1:0] value,
                                                logic [nsr_pkg::ITER_W-1:0] cap,
                                                logic [nsr_pkg::TOL_W-1:0] tol);
    logic [63:0]  scaled;
    logic [63:0]  guess;
    logic [63:0]  next_guess;
    logic [63:0]  square;
    logic [63:0]  error;
    logic [63:0]  bound;
    logic [63:0]  divisor;
    int unsigned  updates;
    logic         finished;
    root_result_t res;
    res.value  = value;
    res.status = nsr_pkg::ST_CONVERGED;
    if (value < 0) begin
      guess      = 64'd0 - ONE_FX;
      res.status = nsr_pkg::ST_NEGATIVE;
    end else if (value == 0) begin
      guess = 64'd0;
    end else if ({32'b0, value} == ONE_FX) begin
      guess = ONE_FX;
    end else begin
      scaled = {32'b0, value} << FRAC_BITS;
      bound  = {48'b0, tol} << FRAC_BITS;
      // Start from the integer part, one lower for whole numbers.
      guess = {32'b0, value} >> FRAC_BITS;
      if (({32'b0, value} & (ONE_FX - 1)) == 0 && guess != 0)
        guess = guess - 1;
      guess = guess << FRAC_BITS;
      if (guess == 0)
        guess = ONE_FX;
      updates  = 0;
      finished = 1'b0;
      while (!finished) begin
        square = guess * guess;
        error  = (square > scaled) ? square - scaled : scaled - square;
        if (error <= bound) begin
          finished = 1'b1;
        end else if (updates >= cap) begin
          res.status = nsr_pkg::ST_CAP;
          finished   = 1'b1;
        end else begin
          divisor    = (guess == 0) ? ONE_FX : guess;
          next_guess = (guess + scaled / divisor) >> 1;
          updates++;
          if (next_guess == guess)
            finished = 1'b1;
          else
            guess = next_guess;
        end
      end
    end
    res.root = guess[nsr_pkg::RES_ROOT_W-1:0];
    return res;
  endfunction

  // Idling share in percent for each side, by progress through the operands.
  function automatic int unsigned idle_percent(bit sender);
    if (operands_accepted * 3 < TOTAL_ITEMS)
      return sender ? 23 : 81;
    else if (operands_accepted * 3 < TOTAL_ITEMS * 2)
      return sender ? 81 : 23;
    else
      return 0;
  endfunction

  task automatic queue_operand(logic signed [nsr_pkg::IN_W-1:0] value);
    port_cmd_t cmd;
    cmd.kind      = CMD_OPERAND;
    cmd.reg_index = nsr_pkg::REG_MAX_ITER;
    cmd.data      = '0;
    cmd.value     = value;
    pending_cmds.push_back(cmd);
    work_outstanding++;
    cycle_allowance += 4 * (300 + longint'(planned_cap + 1) * UPDATE_CYCLES);
  endtask

  task automatic queue_reg_write(nsr_pkg::cfg_reg_e index, int unsigned data);
    port_cmd_t cmd;
    cmd.kind      = CMD_REG_WRITE;
    cmd.reg_index = index;
    cmd.data      = data[nsr_pkg::CFG_DATA_W-1:0];
    cmd.value     = '0;
    pending_cmds.push_back(cmd);
    work_outstanding++;
    cycle_allowance += 200;
    if (index == nsr_pkg::REG_MAX_ITER)
      planned_cap = data & ((1 << nsr_pkg::ITER_W) - 1);
  endtask

  // Returns once every queued transaction has completed.
  task automatic wait_drained();
    do @(posedge clk);
    while (work_outstanding != 0);
  endtask

  function automatic logic signed [nsr_pkg::IN_W-1:0] random_operand();
    int unsigned pick;
    int unsigned k;
    pick = $urandom_range(0, 99);
    if (pick < 10)
      return $urandom() | 32'h8000_0000;
    else if (pick < 14)
      return $urandom_range(0, 1) ? 32'sh0001_0000 : 32'sh0000_0000;
    else if (pick < 30)
      return $urandom_range(1, 65535);
    else if (pick < 45)
      return $urandom_range(1, 32767) << FRAC_BITS;
    else if (pick < 60)
      return $urandom_range(65537, 16 << FRAC_BITS);
    else if (pick < 65) begin
      // Close to a perfect square.
      k = $urandom_range(2, 181);
      return ((k * k) << FRAC_BITS) + $urandom_range(0, 2) - 1;
    end else
      return $urandom() & 32'h7FFF_FFFF;
  endfunction

  // Driver: offers queued transactions and books the ones accepted.
  always @(posedge clk) begin : channel_driver
    port_cmd_t cmd;
    if (rst) begin
      operand_ch.valid <= 1'b0;
      cfg_ch.valid     <= 1'b0;
      iter_cap_reg  = nsr_pkg::ITER_RESET;
      tolerance_reg = '0;
    end else begin
      if (operand_ch.valid && operand_ch.ready) begin
        expected_roots.push_back(predict_root(operand_ch.value, iter_cap_reg,
                                              tolerance_reg));
        operands_accepted++;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == nsr_pkg::REG_MAX_ITER)
          iter_cap_reg = cfg_ch.data[nsr_pkg::ITER_W-1:0];
        else
          tolerance_reg = cfg_ch.data[nsr_pkg::TOL_W-1:0];
        work_outstanding--;
      end
      if ((operand_ch.valid && !operand_ch.ready) || (cfg_ch.valid && !cfg_ch.ready)) begin
        // The current offer stands until it is taken.
      end else if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= idle_percent(1'b1)) begin
        cmd = pending_cmds.pop_front();
        operand_ch.valid <= (cmd.kind == CMD_OPERAND);
        cfg_ch.valid     <= (cmd.kind == CMD_REG_WRITE);
        operand_ch.value <= cmd.value;
        cfg_ch.index     <= cmd.reg_index;
        cfg_ch.data      <= cmd.data;
      end else begin
        operand_ch.valid <= 1'b0;
        cfg_ch.valid     <= 1'b0;
      end
    end
  end

  // Monitor: checks each result transaction against the oldest prediction.
  always @(posedge clk) begin : result_monitor
    root_result_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_roots.size() == 0) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("%0t ns: unexpected result root=%0d status=%0d", $time,
                     result_ch.root, result_ch.status);
        end else begin
          want = expected_roots.pop_front();
          work_outstanding--;
          if (result_ch.root !== want.root || result_ch.status !== want.status) begin
            failures++;
            if (failures <= MAX_REPORTS)
              $display("%0t ns: value 0x%08h: expected root=%0d status=%s, got root=%0d status=%0d",
                       $time, want.value, $signed(want.root), want.status.name(),
                       result_ch.root, result_ch.status);
          end
        end
      end
      result_ch.ready <= ($urandom_range(0, 99) >= idle_percent(1'b0));
    end
  end

  // Watchdog: the allowance grows with every queued transaction.
  initial begin : watchdog
    while (cycle_count < cycle_allowance) @(posedge clk) cycle_count++;
    $display("simulation failed");
    $finish;
  end

  // Stimulus: directed phases first, then random phases with new settings.
  initial begin : stimulus
    int unsigned cap_setting;
    int unsigned tol_setting;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Field extremes and special operands at the reset settings.
    queue_operand(32'sh0000_0000);
    queue_operand(32'sh0001_0000);
    queue_operand(32'shFFFF_FFFF);
    queue_operand(32'sh8000_0000);
    queue_operand(32'shFFFF_0000);
    queue_operand(32'sh0000_0001);
    queue_operand(32'sh0000_FFFF);
    queue_operand(32'sh0000_4000);
    queue_operand(32'sh0001_0001);
    queue_operand(32'sh0002_0000);
    queue_operand(32'sh0004_0000);
    queue_operand(32'sh0001_8000);
    queue_operand(32'sh7FFF_0000);
    queue_operand(32'sh7FFF_FFFF);
    queue_operand(32'sh0010_0000);
    wait_drained();

    // A cap of zero returns the starting guess, flagged unless it passes.
    queue_reg_write(nsr_pkg::REG_MAX_ITER, 0);
    queue_reg_write(nsr_pkg::REG_TOLERANCE, 0);
    queue_operand(32'sh0004_0000);
    queue_operand(32'sh0000_4000);
    queue_operand(32'sh0001_8000);
    wait_drained();
    queue_reg_write(nsr_pkg::REG_TOLERANCE, 65535);
    queue_operand(32'sh0001_8000);
    queue_operand(32'sh0000_8000);
    queue_operand(32'sh0064_0000);
    wait_drained();

    // Random operands under a spread of caps and tolerances.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          cap_setting = 4096;
          tol_setting = 0;
        end
        1: begin
          cap_setting = 1;
          tol_setting = 65535;
        end
        2: begin
          cap_setting = 1;
          tol_setting = 0;
        end
        3: begin
          cap_setting = 4096;
          tol_setting = 65535;
        end
        default: begin
          cap_setting = $urandom_range(0, 1) ? $urandom_range(1, 12) : $urandom_range(13, 4096);
          case ($urandom_range(0, 2))
            0: tol_setting = 0;
            1: tol_setting = $urandom_range(1, 255);
            default: tol_setting = $urandom_range(0, 65535);
          endcase
        end
      endcase
      queue_reg_write(nsr_pkg::REG_MAX_ITER, cap_setting);
      queue_reg_write(nsr_pkg::REG_TOLERANCE, tol_setting);
      for (int i = 0; i < PHASE_ITEMS; i++)
        queue_operand(random_operand());
      wait_drained();
    end

    // Allow time for any stray result to show up.
    repeat (END_CYCLES) @(posedge clk);
    if (failures == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
